/* hdl/sct_pkg.sv */
package sct_pkg;

    localparam int POS_BITS   = 32;
    localparam int NUM_BITS   = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // ASCII codes the lexer looks at by name
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_F  = 8'h66;

    typedef enum logic [7:0] {
        M_IDLE    = 8'b0000_0001,
        M_IDENT   = 8'b0000_0010,
        M_BAR     = 8'b0000_0100,
        M_NUMBER  = 8'b0000_1000,
        M_STRING  = 8'b0001_0000,
        M_COMMENT = 8'b0010_0000,
        M_HASH2   = 8'b0100_0000,
        M_COMMAAT = 8'b1000_0000
    } t_lex_mode;

    typedef enum logic [3:0] {
        K_SKIP     = 4'd0,
        K_IDENT    = 4'd1,
        K_NUMBER   = 4'd2,
        K_STRING   = 4'd3,
        K_BOOL     = 4'd4,
        K_LPAREN   = 4'd5,
        K_RPAREN   = 4'd6,
        K_VECPAREN = 4'd7,
        K_QUOTE    = 4'd8,
        K_BACKTICK = 4'd9,
        K_COMMA    = 4'd10,
        K_COMMA_AT = 4'd11,
        K_DOT      = 4'd12,
        K_EOF      = 4'd13
    } t_kind;

    typedef enum logic [1:0] {
        E_NONE    = 2'd0,
        E_INVALID = 2'd1,
        E_DOT_END = 2'd2,
        E_UNTERM  = 2'd3
    } t_err;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_input;
    } t_item;

    typedef struct packed {
        logic [7:0]  char_out;
        t_kind       token_kind;
        logic        token_first;
        logic        token_last;
        logic [31:0] token_position;
        logic [31:0] number_value;
        t_err        error_code;
        logic        last;
    } t_res;

    typedef struct packed {
        t_lex_mode           mode;
        t_err                err;
        logic [POS_BITS-1:0] start;
        logic [NUM_BITS-1:0] acc;
    } t_lex_state;

    // up to two result beats written into the output buffer together in the same cycle
    typedef struct packed {
        logic [1:0] num;
        t_res       first_beat;
        t_res       second_beat;
    } t_push;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic sym_char(input logic [7:0] c);
        return c inside {8'h21, 8'h24, 8'h25, 8'h26, 8'h2A, 8'h2F, 8'h3A,
                         8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h5E, 8'h5F, 8'h7E};
    endfunction

    function automatic logic ident_head(input logic [7:0] c);
        return is_alpha(c) || sym_char(c);
    endfunction

    function automatic logic ident_tail(input logic [7:0] c);
        return ident_head(c) || is_digit(c) || c == CH_PLUS || c == CH_MINUS
            || c == CH_DOT || c == CH_AT;
    endfunction

    function automatic logic is_dot_sub(input logic [7:0] c);
        return ident_head(c) || c == CH_PLUS || c == CH_MINUS || c == CH_AT
            || c == CH_DOT;
    endfunction

endpackage

/* hdl/sct_classify.sv */
module sct_classify (
    input  sct_pkg::t_lex_state          i_state,
    input  logic [sct_pkg::POS_BITS-1:0] i_pos,
    input  logic [7:0]                   i_char,
    input  logic                         i_has,
    input  logic [7:0]                   i_look,
    output sct_pkg::t_lex_state          o_state,
    output sct_pkg::t_res                o_res
);
    import sct_pkg::*;

    t_lex_state          n;
    t_kind               kind;
    logic                first;
    logic                tlast;
    logic                token;
    logic [NUM_BITS-1:0] num;
    logic [NUM_BITS+3:0] acc_wide;
    logic [NUM_BITS+3:0] prod;
    logic [NUM_BITS-1:0] sat;

    // acc*10 + digit, clamp to all ones on overflow
    assign acc_wide = {4'b0000, i_state.acc};
    assign prod     = (acc_wide << 3) + (acc_wide << 1)
                    + {{NUM_BITS{1'b0}}, i_char[3:0]};
    assign sat      = (|prod[NUM_BITS+3:NUM_BITS]) ? {NUM_BITS{1'b1}}
                                                   : prod[NUM_BITS-1:0];

    always_comb begin
        n     = i_state;
        kind  = K_SKIP;
        first = 1'b0;
        tlast = 1'b0;
        token = 1'b0;
        num   = '0;

        if (i_state.err == E_NONE) begin
            unique case (i_state.mode)
                M_IDENT: begin
                    kind  = K_IDENT;
                    token = 1'b1;
                    tlast = !(i_has && ident_tail(i_look));
                end
                M_BAR: begin
                    kind  = K_IDENT;
                    token = 1'b1;
                    tlast = (i_char == CH_BAR) || !i_has;
                end
                M_NUMBER: begin
                    n.acc = sat;
                    kind  = K_NUMBER;
                    token = 1'b1;
                    tlast = !(i_has && is_digit(i_look));
                    if (tlast) begin
                        num = sat;
                    end
                end
                M_STRING: begin
                    kind  = K_STRING;
                    token = 1'b1;
                    if (i_char == CH_DQUOTE) begin
                        tlast = 1'b1;
                    end else if (!i_has) begin
                        tlast = 1'b1;
                        n.err = E_UNTERM;
                    end
                end
                M_COMMENT: begin
                    if (i_char == CH_LF || i_char == CH_CR) begin
                        n.mode = M_IDLE;
                    end
                end
                M_HASH2: begin
                    kind  = (i_char == CH_LPAREN) ? K_VECPAREN : K_BOOL;
                    token = 1'b1;
                    tlast = 1'b1;
                end
                M_COMMAAT: begin
                    kind  = K_COMMA_AT;
                    token = 1'b1;
                    tlast = 1'b1;
                end
                M_IDLE: begin
                    if (i_char == CH_SEMI) begin
                        n.mode = M_COMMENT;
                    end else if (!is_space(i_char)) begin
                        n.start = i_pos;
                        first   = 1'b1;
                        token   = 1'b1;
                        tlast   = 1'b1;
                        if (ident_head(i_char) || i_char == CH_PLUS
                                || i_char == CH_MINUS) begin
                            kind = K_IDENT;
                            if (i_has && ident_tail(i_look)) begin
                                tlast  = 1'b0;
                                n.mode = M_IDENT;
                            end
                        end else if (i_char == CH_BAR) begin
                            kind = K_IDENT;
                            if (i_has) begin
                                tlast  = 1'b0;
                                n.mode = M_BAR;
                            end
                        end else if (i_char == CH_DOT) begin
                            if (!i_has) begin
                                n.err = E_DOT_END;
                                token = 1'b0;
                            end else if (is_dot_sub(i_look)) begin
                                kind   = K_IDENT;
                                tlast  = 1'b0;
                                n.mode = M_IDENT;
                            end else begin
                                kind = K_DOT;
                            end
                        end else if (i_char == CH_HASH) begin
                            if (i_has && (i_look == CH_LOW_T || i_look == CH_LOW_F
                                    || i_look == CH_LPAREN)) begin
                                kind   = (i_look == CH_LPAREN) ? K_VECPAREN : K_BOOL;
                                tlast  = 1'b0;
                                n.mode = M_HASH2;
                            end else begin
                                n.err = E_INVALID;
                                token = 1'b0;
                            end
                        end else if (is_digit(i_char)) begin
                            n.acc = {{(NUM_BITS-4){1'b0}}, i_char[3:0]};
                            kind  = K_NUMBER;
                            if (i_has && is_digit(i_look)) begin
                                tlast  = 1'b0;
                                n.mode = M_NUMBER;
                            end else begin
                                num = {{(NUM_BITS-4){1'b0}}, i_char[3:0]};
                            end
                        end else if (i_char == CH_DQUOTE) begin
                            kind = K_STRING;
                            if (i_has) begin
                                tlast  = 1'b0;
                                n.mode = M_STRING;
                            end else begin
                                n.err = E_UNTERM;
                            end
                        end else if (i_char == CH_LPAREN || i_char == CH_LBRACK) begin
                            kind = K_LPAREN;
                        end else if (i_char == CH_RPAREN || i_char == CH_RBRACK) begin
                            kind = K_RPAREN;
                        end else if (i_char == CH_SQUOTE) begin
                            kind = K_QUOTE;
                        end else if (i_char == CH_BTICK) begin
                            kind = K_BACKTICK;
                        end else if (i_char == CH_COMMA) begin
                            kind = K_COMMA;
                            if (i_has && i_look == CH_AT) begin
                                kind   = K_COMMA_AT;
                                tlast  = 1'b0;
                                n.mode = M_COMMAAT;
                            end
                        end else begin
                            n.err = E_INVALID;
                            token = 1'b0;
                        end
                    end
                end
                default: begin
                    n.mode = M_IDLE;
                end
            endcase
        end

        if (!token) begin
            kind  = K_SKIP;
            first = 1'b0;
            tlast = 1'b0;
            num   = '0;
        end
        if (tlast || n.err != E_NONE) begin
            n.mode = M_IDLE;
        end

        o_state              = n;
        o_res.char_out       = i_char;
        o_res.token_kind     = kind;
        o_res.token_first    = first;
        o_res.token_last     = tlast;
        o_res.token_position = token ? 32'(n.start) : 32'(i_pos);
        o_res.number_value   = 32'(num);
        o_res.error_code     = n.err;
        o_res.last           = 1'b0;
    end

endmodule

/* hdl/sct_out_fifo.sv */
module sct_out_fifo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sct_pkg::t_push                   i_push,
    input  logic                             i_pop,
    output sct_pkg::t_res                    o_head,
    output logic [sct_pkg::FIFO_CNT_W-1:0]   o_count
);
    import sct_pkg::*;

    t_res                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic [FIFO_PTR_W-1:0] wr_ptr_1;

    assign wr_ptr_1 = r_wr_ptr + FIFO_PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first_beat;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push.second_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(i_push.num);
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            r_count <= r_count + FIFO_CNT_W'(i_push.num) - FIFO_CNT_W'(i_pop);
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

/* hdl/sexpr_char_tokenizer.sv */
// Scheme s-expression tokenizer. Each input beat carries one ASCII byte; the
// block holds it back until the next beat so the following byte can act as
// lookahead, then sends the held byte out with its token kind, first/last
// marks, the offset where its token starts and, on the last digit of a
// number, the saturated decimal value. Whitespace and ';' comments come out
// as skip. The first error (invalid character, dot at end, unterminated
// string) sticks and turns every later byte into skip. A beat with
// end_of_input set flushes the held byte and adds an EOF beat, then returns
// all state to its reset values. Rate: one input beat per cycle while the
// result buffer has room for two beats. Classification is a single pass of
// logic from the state registers into a four-entry result buffer; two beats
// of room are needed because an end-of-input beat writes two results when a
// byte is held. A result is written into the buffer by the beat after its
// byte; the beat with the first byte after reset or end of input writes none.
module sexpr_char_tokenizer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  sct_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_stall,
    output sct_pkg::t_res  o_res
);
    import sct_pkg::*;

    logic [7:0]            r_held_char;
    logic                  r_held_valid;
    t_lex_state            r_state;
    logic [POS_BITS-1:0]   r_pos;

    logic [7:0]            n_held_char;
    logic                  n_held_valid;
    t_lex_state            n_state;
    logic [POS_BITS-1:0]   n_pos;

    t_lex_state            cls_state;
    t_res                  cls_res;
    t_lex_state            flush_state;
    logic [POS_BITS-1:0]   flush_pos;
    t_err                  eof_err;
    t_res                  eof_res;
    t_res                  flush_res;
    t_res                  step_res;
    t_push                 push;
    logic                  accept;
    logic                  pop;
    logic [FIFO_CNT_W-1:0] fifo_count;

    // classify the held byte against the incoming one (no lookahead at end)
    sct_classify u_classify (
        .i_state (r_state),
        .i_pos   (r_pos),
        .i_char  (r_held_char),
        .i_has   (!i_item.end_of_input),
        .i_look  (i_item.char_in),
        .o_state (cls_state),
        .o_res   (cls_res)
    );

    sct_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (o_res),
        .o_count (fifo_count)
    );

    // hold off input unless two result beats fit
    assign o_stall = fifo_count > FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign accept  = i_valid && !o_stall;
    assign o_valid = fifo_count != '0;
    assign pop     = o_valid && !i_stall;

    always_comb begin
        // state as it stands once the held byte is flushed
        flush_state = r_held_valid ? cls_state : r_state;
        flush_pos   = r_held_valid ? r_pos + POS_BITS'(1) : r_pos;
        eof_err     = flush_state.err;
        if (flush_state.mode == M_STRING && eof_err == E_NONE) begin
            eof_err = E_UNTERM;
        end

        eof_res                = '0;
        eof_res.token_kind     = K_EOF;
        eof_res.token_first    = 1'b1;
        eof_res.token_last     = 1'b1;
        eof_res.token_position = 32'(flush_pos);
        eof_res.error_code     = eof_err;
        eof_res.last           = 1'b1;

        flush_res      = cls_res;
        flush_res.last = 1'b0;
        step_res       = cls_res;
        step_res.last  = 1'b1;

        push = '0;
        if (accept) begin
            if (i_item.end_of_input) begin
                push.num         = r_held_valid ? 2'd2 : 2'd1;
                push.first_beat  = r_held_valid ? flush_res : eof_res;
                push.second_beat = eof_res;
            end else if (r_held_valid) begin
                push.num        = 2'd1;
                push.first_beat = step_res;
            end
        end

        n_held_char  = r_held_char;
        n_held_valid = r_held_valid;
        n_state      = r_state;
        n_pos        = r_pos;
        if (accept) begin
            if (i_item.end_of_input) begin
                // drop everything back to reset values
                n_held_char  = '0;
                n_held_valid = 1'b0;
                n_state      = '{mode: M_IDLE, err: E_NONE, start: '0, acc: '0};
                n_pos        = '0;
            end else begin
                if (r_held_valid) begin
                    n_state = cls_state;
                    n_pos   = r_pos + POS_BITS'(1);
                end
                n_held_char  = i_item.char_in;
                n_held_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_char  <= '0;
            r_held_valid <= 1'b0;
            r_state      <= '{mode: M_IDLE, err: E_NONE, start: '0, acc: '0};
            r_pos        <= '0;
        end else begin
            r_held_char  <= n_held_char;
            r_held_valid <= n_held_valid;
            r_state      <= n_state;
            r_pos        <= n_pos;
        end
    end

    // buffer never overruns: input is held off while two beats will not fit
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result buffer overrun");

    // end of input returns the lexer to its reset state
    a_eoi_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_item.end_of_input |=>
            !r_held_valid && r_pos == '0 && r_state.err == E_NONE
            && r_state.mode == M_IDLE)
        else $error("state not cleared after end of input");

    // an error sticks until end of input
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.err != E_NONE && !(accept && i_item.end_of_input) |=>
            r_state.err == $past(r_state.err))
        else $error("sticky error changed");

    // once in error the lexer stays between tokens
    a_err_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.err != E_NONE |-> r_state.mode == M_IDLE)
        else $error("lexer inside a token while in error");

    // a plain byte always becomes the held byte
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_item.end_of_input |=>
            r_held_valid && r_held_char == $past(i_item.char_in))
        else $error("input byte not held");

endmodule
